// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the publish packet parser.
// No dependencies; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define PPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define PPP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPP_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/ppp_pkg.sv -----
// Types and constants of the publish packet parser.
// No dependencies; used by ppp_result_queue and publish_packet_parser.
package ppp_pkg;

    localparam int LENGTH_BITS_DEF = 28;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int REM_LEN_W       = 28;
    localparam int BYTE_W          = 8;
    localparam int HALF_W          = 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_ID_HI,
        PH_ID_LO,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TOPIC,
        KIND_PAYLOAD,
        KIND_HEADER,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [BYTE_W-1:0]      data;
        logic [HALF_W-1:0]      topic_len;
        logic [HALF_W-1:0]      pkt_id;
        logic [1:0]             qos;
        logic                   dup;
        logic                   retain;
        logic [REM_LEN_W-1:0]   plen;
        logic                   last;
    } result_t;

endpackage

// ----- rtl/publish_packet_parser.sv -----
// Top level of the publish packet parser: input register, parse step, result queue.
// Depends on ppp_pkg, ppp_result_queue and assert_macros.svh.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  input   | in_valid  | in_stall  | in_byte first_byte hdr_* rem_length
//  result  | out_valid | out_stall | result_kind out_byte topic_length msg_id ...
//
// One input byte per clock unless stalled; a byte is staged, then its results queued.
// A byte that yields two results (last topic byte with header done or length
// error) is one transaction in and two out; the result queue (QUEUE_DEPTH deep)
// absorbs that, and the input stalls only when fewer than two queue slots are free.
// Reset clears the parse phase, counters and queue; no clearing pass is needed.
`include "assert_macros.svh"

module publish_packet_parser #(
    parameter int LENGTH_BITS = ppp_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ppp_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           first_byte,
    input  logic [1:0]                     hdr_qos,
    input  logic                           hdr_dup,
    input  logic                           hdr_retain,
    input  logic [ppp_pkg::REM_LEN_W-1:0]  rem_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     result_kind,
    output logic [ppp_pkg::BYTE_W-1:0]     out_byte,
    output logic [ppp_pkg::HALF_W-1:0]     topic_length,
    output logic [ppp_pkg::HALF_W-1:0]     msg_id,
    output logic [1:0]                     out_qos,
    output logic                           out_dup,
    output logic                           out_retain,
    output logic [ppp_pkg::REM_LEN_W-1:0]  payload_length,
    output logic                           last_of_packet
);

    // Byte counters never need more than the remaining length field carries.
    localparam int CW = (LENGTH_BITS < ppp_pkg::REM_LEN_W) ? LENGTH_BITS
                                                          : ppp_pkg::REM_LEN_W;
    localparam int HW = ppp_pkg::HALF_W;
    localparam int BW = ppp_pkg::BYTE_W;

    // ---------------------------------------------------------------- input register
    logic              in_vld_reg;
    logic [BW-1:0]     in_byte_reg;
    logic              in_first_reg;
    logic [3:0]        in_flags_reg;
    logic [CW-1:0]     in_len_reg;
    logic              room2;
    logic              fire;
    logic              in_accept;

    assign fire      = in_vld_reg && room2;
    assign in_stall  = in_vld_reg && !room2;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= in_byte;
            in_first_reg <= first_byte;
            in_flags_reg <= {hdr_qos, hdr_dup, hdr_retain};
            in_len_reg   <= rem_length[CW-1:0];
        end
    end

    // ---------------------------------------------------------------- parse state
    ppp_pkg::phase_t   phase_reg, phase_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [HW-1:0]     tlen_reg, tlen_next;
    logic [HW-1:0]     tleft_reg, tleft_next;
    logic [HW-1:0]     id_reg, id_next;
    logic [3:0]        flags_reg, flags_next;

    // A first byte restarts the packet before the byte itself is parsed.
    ppp_pkg::phase_t   eff_phase;
    logic [CW-1:0]     eff_left;
    logic [HW-1:0]     eff_tlen;
    logic [HW-1:0]     eff_tleft;
    logic [HW-1:0]     eff_id;
    logic [3:0]        eff_flags;
    logic [CW-1:0]     left_dec;
    logic [HW-1:0]     tlen_lo;
    logic [HW-1:0]     tleft_dec;
    logic [HW-1:0]     id_full;
    logic              left_zero;
    logic              dec_zero;
    logic              qos_nz;
    logic              hdr_done;

    assign eff_phase = in_first_reg ? ppp_pkg::PH_TLEN_HI : phase_reg;
    assign eff_left  = in_first_reg ? in_len_reg : left_reg;
    assign eff_tlen  = in_first_reg ? '0 : tlen_reg;
    assign eff_tleft = in_first_reg ? '0 : tleft_reg;
    assign eff_id    = in_first_reg ? '0 : id_reg;
    assign eff_flags = in_first_reg ? in_flags_reg : flags_reg;

    assign left_dec  = eff_left - CW'(1);
    assign left_zero = (eff_left == '0);
    assign dec_zero  = (left_dec == '0);
    assign qos_nz    = (eff_flags[3:2] != 2'd0);
    assign tlen_lo   = {eff_tlen[HW-1:BW], in_byte_reg};
    assign tleft_dec = eff_tleft - HW'(1);
    assign id_full   = {eff_id[HW-1:BW], in_byte_reg};

    // Header is complete on this byte (only meaningful when a byte is counted).
    always_comb
    begin
        case (eff_phase)
            ppp_pkg::PH_TLEN_LO: hdr_done = (tlen_lo == '0) && !qos_nz;
            ppp_pkg::PH_TOPIC:   hdr_done = (tleft_dec == '0) && !qos_nz;
            ppp_pkg::PH_ID_LO:   hdr_done = 1'b1;
            default:             hdr_done = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        id_next    = id_reg;
        flags_next = flags_reg;
        if (fire)
        begin
            phase_next = eff_phase;
            left_next  = eff_left;
            tlen_next  = eff_tlen;
            tleft_next = eff_tleft;
            id_next    = eff_id;
            flags_next = eff_flags;
            if (eff_phase == ppp_pkg::PH_IDLE)
            begin
                phase_next = ppp_pkg::PH_IDLE;
            end
            else if (left_zero)
            begin
                phase_next = ppp_pkg::PH_IDLE;
            end
            else
            begin
                left_next = left_dec;
                case (eff_phase)
                    ppp_pkg::PH_TLEN_HI:
                    begin
                        tlen_next  = {in_byte_reg, BW'(0)};
                        phase_next = ppp_pkg::PH_TLEN_LO;
                    end
                    ppp_pkg::PH_TLEN_LO:
                    begin
                        tlen_next  = tlen_lo;
                        tleft_next = tlen_lo;
                        if (tlen_lo != '0)
                        begin
                            phase_next = ppp_pkg::PH_TOPIC;
                        end
                        else
                        begin
                            phase_next = ppp_pkg::PH_ID_HI;
                        end
                    end
                    ppp_pkg::PH_TOPIC:
                    begin
                        tleft_next = tleft_dec;
                        if (tleft_dec == '0)
                        begin
                            phase_next = ppp_pkg::PH_ID_HI;
                        end
                    end
                    ppp_pkg::PH_ID_HI:
                    begin
                        id_next    = {in_byte_reg, BW'(0)};
                        phase_next = ppp_pkg::PH_ID_LO;
                    end
                    ppp_pkg::PH_ID_LO:
                    begin
                        id_next = id_full;
                    end
                    default:
                    begin
                        phase_next = dec_zero ? ppp_pkg::PH_IDLE : ppp_pkg::PH_PAYLOAD;
                    end
                endcase
                // Header done moves on to payload; a short packet drops to idle.
                if (eff_phase != ppp_pkg::PH_PAYLOAD)
                begin
                    if (hdr_done)
                    begin
                        phase_next = dec_zero ? ppp_pkg::PH_IDLE : ppp_pkg::PH_PAYLOAD;
                    end
                    else if (dec_zero)
                    begin
                        phase_next = ppp_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

    // Result outputs of the parse step.
    ppp_pkg::result_t  res0, res1;
    logic [1:0]        res_cnt;
    logic [1:0]        push_cnt;

    always_comb
    begin
        ppp_pkg::result_t base;
        ppp_pkg::result_t tail;
        logic             tail_vld;
        base        = '0;
        base.qos    = eff_flags[3:2];
        base.dup    = eff_flags[1];
        base.retain = eff_flags[0];
        tail        = base;
        tail_vld    = hdr_done || dec_zero;
        if (hdr_done)
        begin
            tail.kind      = ppp_pkg::KIND_HEADER;
            tail.topic_len = (eff_phase == ppp_pkg::PH_TLEN_LO) ? tlen_lo : eff_tlen;
            tail.pkt_id    = (eff_phase == ppp_pkg::PH_ID_LO) ? id_full : eff_id;
            tail.plen      = ppp_pkg::REM_LEN_W'(left_dec);
            tail.last      = dec_zero;
        end
        else
        begin
            tail.kind = ppp_pkg::KIND_ERROR;
            tail.last = 1'b1;
        end
        res0    = base;
        res1    = tail;
        res_cnt = 2'd0;
        if (eff_phase == ppp_pkg::PH_IDLE)
        begin
            res_cnt = 2'd0;
        end
        else if (left_zero)
        begin
            res0.kind = ppp_pkg::KIND_ERROR;
            res0.last = 1'b1;
            res_cnt   = 2'd1;
        end
        else if (eff_phase == ppp_pkg::PH_PAYLOAD)
        begin
            res0.kind = ppp_pkg::KIND_PAYLOAD;
            res0.data = in_byte_reg;
            res0.last = dec_zero;
            res_cnt   = 2'd1;
        end
        else if (eff_phase == ppp_pkg::PH_TOPIC)
        begin
            res0.kind = ppp_pkg::KIND_TOPIC;
            res0.data = in_byte_reg;
            res_cnt   = tail_vld ? 2'd2 : 2'd1;
        end
        else
        begin
            res0    = tail;
            res_cnt = tail_vld ? 2'd1 : 2'd0;
        end
    end

    assign push_cnt = fire ? res_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ppp_pkg::PH_IDLE;
            left_reg  <= '0;
            tlen_reg  <= '0;
            tleft_reg <= '0;
            id_reg    <= '0;
            flags_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
        end
    end

    // ---------------------------------------------------------------- result queue
    ppp_pkg::result_t  head;

    ppp_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .wdata0   (res0),
        .wdata1   (res1),
        .room2    (room2),
        .valid    (out_valid),
        .stall    (out_stall),
        .head     (head)
    );

    assign result_kind    = head.kind;
    assign out_byte       = head.data;
    assign topic_length   = head.topic_len;
    assign msg_id         = head.pkt_id;
    assign out_qos        = head.qos;
    assign out_dup        = head.dup;
    assign out_retain     = head.retain;
    assign payload_length = head.plen;
    assign last_of_packet = head.last;

    // ---------------------------------------------------------------- assertions
    `PPP_ASSERT(a_hdr_last, clk, rst_n,
        out_valid && (result_kind == ppp_pkg::KIND_HEADER) |->
        (last_of_packet == (payload_length == '0)), "header last flag mismatch")
    `PPP_ASSERT(a_err_last, clk, rst_n,
        out_valid && (result_kind == ppp_pkg::KIND_ERROR) |-> last_of_packet,
        "length error not marked last")
    `PPP_NEVER(a_payload_left, clk, rst_n,
        (phase_reg == ppp_pkg::PH_PAYLOAD) && (left_reg == '0),
        "payload phase with no bytes left")
    `PPP_ASSERT(a_stall_room, clk, rst_n,
        in_vld_reg && !in_stall |=> !(in_vld_reg && $past(!in_accept)),
        "staged byte not consumed")

endmodule

// ----- rtl/ppp_result_queue.sv -----
// Small result queue: takes zero, one or two results per cycle, hands out one unless stalled.
// Depends on ppp_pkg (result_t).
module ppp_result_queue #(
    parameter int DEPTH = ppp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  ppp_pkg::result_t  wdata0,
    input  ppp_pkg::result_t  wdata1,
    output logic              room2,
    output logic              valid,
    input  logic              stall,
    output ppp_pkg::result_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    ppp_pkg::result_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr1;
    logic              pop;

    assign wr_ptr1 = wrap_inc(wr_ptr_reg);
    assign valid   = (count_reg != '0);
    assign pop     = valid && !stall;
    assign room2   = (count_reg <= CNT_W'(DEPTH - 2));
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_cnt == 2'd1)
        begin
            wr_ptr_next = wr_ptr1;
        end
        else if (push_cnt == 2'd2)
        begin
            wr_ptr_next = wrap_inc(wr_ptr1);
        end
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wdata0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr1] <= wdata1;
        end
    end

endmodule
